// File: hw/rtl/src_pkg.sv
// shared types, register indexes and widths for the sensor compensation pipeline
// no dependencies; every rtl file of the block takes names from here by scope
package src_pkg;

  localparam int NUM_W      = 64;
  localparam int DEN_W      = 31;
  localparam int DIV_STAGES = NUM_W;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_TEMP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_LO = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_HI = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_P9 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HUM      = 3'd4;

  localparam logic signed [31:0] HUM_MAX = 32'sd419430400;

  typedef struct packed {
    logic [7:0] press_msb;
    logic [7:0] press_lsb;
    logic [7:0] press_xlsb;
    logic [7:0] temp_msb;
    logic [7:0] temp_lsb;
    logic [7:0] temp_xlsb;
    logic [7:0] hum_msb;
    logic [7:0] hum_lsb;
  } in_t;

  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
    logic               pressure_invalid;
    logic [16:0]        humidity_q22_10;
  } out_t;

  typedef struct packed {
    logic [47:0] temp;
    logic [63:0] press_lo;
    logic [63:0] press_hi;
    logic [15:0] press_p9;
    logic [63:0] hum;
  } coef_t;

  typedef struct packed {
    logic signed [31:0] tf;
    logic signed [31:0] temp_centi;
    logic [19:0]        adc_p;
    logic [15:0]        adc_h;
  } temp_res_t;

  typedef struct packed {
    logic signed [31:0] tf;
    logic signed [31:0] temp_centi;
    logic [19:0]        adc_p;
    logic [16:0]        hum;
  } hum_res_t;

  typedef struct packed {
    logic signed [31:0]      temp_centi;
    logic [16:0]             hum;
    logic [NUM_W-1:0]        num;
    logic signed [DEN_W-1:0] den;
  } pre_res_t;

  typedef struct packed {
    logic signed [31:0] temp_centi;
    logic [16:0]        hum;
    logic               invalid;
    logic               qneg;
  } div_side_t;

  typedef struct packed {
    logic signed [31:0] temp_centi;
    logic [16:0]        hum;
    logic               invalid;
    logic               qneg;
    logic [NUM_W-1:0]   quo;
  } div_res_t;

endpackage

// File: hw/rtl/src_temp.sv
// temperature stages: unpacks the burst and computes fine and centi-degree temperature
// depends on src_pkg
module src_temp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  src_pkg::coef_t        coef,
  input  logic                  in_vld,
  input  src_pkg::in_t          in_data,
  output logic                  out_vld,
  output src_pkg::temp_res_t    out_data
);

  logic [3:0] vld_r;
  logic [35:0] side_r [4];

  logic [19:0] adc_t;
  logic [19:0] adc_p;
  logic [15:0] adc_h;
  logic signed [17:0] t1s;
  logic signed [15:0] t2;
  logic signed [15:0] t3;

  logic signed [17:0] x_nxt, x_r1;
  logic signed [17:0] d_nxt, d_r1;
  logic signed [31:0] xp, dp, a_nxt, a_r2, dd_nxt, dd_r2;
  logic signed [31:0] bp, tf_nxt, tf_r3, tf_r4;
  logic signed [31:0] tm, temp_nxt, temp_r4;

  assign adc_t = {in_data.temp_msb, in_data.temp_lsb, in_data.temp_xlsb[7:4]};
  assign adc_p = {in_data.press_msb, in_data.press_lsb, in_data.press_xlsb[7:4]};
  assign adc_h = {in_data.hum_msb, in_data.hum_lsb};
  assign t1s   = $signed({2'b00, coef.temp[15:0]});
  assign t2    = $signed(coef.temp[31:16]);
  assign t3    = $signed(coef.temp[47:32]);

  always_comb begin
    x_nxt    = $signed({1'b0, adc_t[19:3]}) - (t1s <<< 1);
    d_nxt    = $signed({2'b00, adc_t[19:4]}) - t1s;
    xp       = x_r1 * t2;
    a_nxt    = xp >>> 11;
    dp       = d_r1 * d_r1;
    dd_nxt   = dp >>> 12;
    bp       = dd_r2 * t3;
    tf_nxt   = a_r2 + (bp >>> 14);
    tm       = (tf_r3 <<< 2) + tf_r3 + 32'sd128;
    temp_nxt = tm >>> 8;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    x_r1    <= x_nxt;
    d_r1    <= d_nxt;
    a_r2    <= a_nxt;
    dd_r2   <= dd_nxt;
    tf_r3   <= tf_nxt;
    tf_r4   <= tf_r3;
    temp_r4 <= temp_nxt;
    side_r[0] <= {adc_p, adc_h};
    for (int i = 1; i < 4; i++) begin
      side_r[i] <= side_r[i-1];
    end
  end

  assign out_vld             = vld_r[3];
  assign out_data.tf         = tf_r4;
  assign out_data.temp_centi = temp_r4;
  assign out_data.adc_p      = side_r[3][35:16];
  assign out_data.adc_h      = side_r[3][15:0];

endmodule

// File: hw/rtl/src_hum.sv
// humidity stages: compensated relative humidity from fine temperature, clamped
// depends on src_pkg
module src_hum (
  input  logic                  clk,
  input  logic                  rst_n,
  input  src_pkg::coef_t        coef,
  input  logic                  in_vld,
  input  src_pkg::temp_res_t    in_data,
  output logic                  out_vld,
  output src_pkg::hum_res_t     out_data
);

  logic [8:0] vld_r;
  src_pkg::temp_res_t side_r [9];

  logic signed [8:0]  h1;
  logic signed [15:0] h2;
  logic signed [8:0]  h3;
  logic signed [11:0] h5;
  logic signed [7:0]  h6;

  logic signed [31:0] v_nxt, v_r1;
  logic signed [31:0] p5, p6, p3, m5_r2, m6_r2, m3_r2;
  logic signed [31:0] ha_pre, ha_nxt, ha_r3, ha_r4, ha_r5, hc_nxt, hc_r3;
  logic signed [31:0] hcs_nxt, hcs_r4, hp, hcp_nxt, hcp_r5;
  logic signed [31:0] vv_nxt, vv_r6, vv_r7;
  logic signed [31:0] s, sp, sq_nxt, sq_r7;
  logic signed [31:0] tp, res_nxt, res_r8;
  logic signed [31:0] clip;
  logic [16:0]        hum_nxt, hum_r9;

  assign h1 = $signed({1'b0, coef.hum[7:0]});
  assign h2 = $signed(coef.hum[23:8]);
  assign h3 = $signed({1'b0, coef.hum[31:24]});
  assign h5 = $signed(coef.hum[55:44]);
  assign h6 = $signed(coef.hum[63:56]);

  always_comb begin
    v_nxt   = in_data.tf - 32'sd76800;
    p5      = v_r1 * h5;
    p6      = v_r1 * h6;
    p3      = v_r1 * h3;
    ha_pre  = $signed({2'b00, side_r[1].adc_h, 14'b0})
              - ($signed({coef.hum[43:32], 20'b0}) + m5_r2) + 32'sd16384;
    ha_nxt  = ha_pre >>> 15;
    hc_nxt  = m6_r2 * m3_r2;
    hcs_nxt = (hc_r3 >>> 10) + 32'sd2097152;
    hp      = hcs_r4 * h2 + 32'sd8192;
    hcp_nxt = hp >>> 14;
    vv_nxt  = ha_r5 * hcp_r5;
    s       = vv_r6 >>> 15;
    sp      = s * s;
    sq_nxt  = sp >>> 7;
    tp      = sq_r7 * h1;
    res_nxt = vv_r7 - (tp >>> 4);
    if (res_r8 < 32'sd0) begin
      clip = 32'sd0;
    end else if (res_r8 > src_pkg::HUM_MAX) begin
      clip = src_pkg::HUM_MAX;
    end else begin
      clip = res_r8;
    end
    hum_nxt = clip[28:12];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[7:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    v_r1   <= v_nxt;
    m5_r2  <= p5;
    m6_r2  <= p6 >>> 10;
    m3_r2  <= (p3 >>> 11) + 32'sd32768;
    ha_r3  <= ha_nxt;
    hc_r3  <= hc_nxt;
    hcs_r4 <= hcs_nxt;
    ha_r4  <= ha_r3;
    hcp_r5 <= hcp_nxt;
    ha_r5  <= ha_r4;
    vv_r6  <= vv_nxt;
    sq_r7  <= sq_nxt;
    vv_r7  <= vv_r6;
    res_r8 <= res_nxt;
    hum_r9 <= hum_nxt;
    side_r[0] <= in_data;
    for (int i = 1; i < 9; i++) begin
      side_r[i] <= side_r[i-1];
    end
  end

  assign out_vld             = vld_r[8];
  assign out_data.tf         = side_r[8].tf;
  assign out_data.temp_centi = side_r[8].temp_centi;
  assign out_data.adc_p      = side_r[8].adc_p;
  assign out_data.hum        = hum_r9;

endmodule

// File: hw/rtl/src_ppre.sv
// pressure stages ahead of the divider: builds the 64-bit numerator and the 31-bit divisor
// depends on src_pkg
module src_ppre (
  input  logic                  clk,
  input  logic                  rst_n,
  input  src_pkg::coef_t        coef,
  input  logic                  in_vld,
  input  src_pkg::hum_res_t     in_data,
  output logic                  out_vld,
  output src_pkg::pre_res_t     out_data
);

  logic [5:0] vld_r;
  src_pkg::hum_res_t side_r [6];

  logic signed [16:0] p1;
  logic signed [15:0] p2, p3, p5, p6;
  logic signed [63:0] p4w;

  logic signed [33:0] v1_nxt, v1_r1;
  logic signed [63:0] v1sq_nxt, v1sq_r2, m5_nxt, m5_r2, m5_r3, m2_nxt, m2_r2, m2_r3;
  logic signed [63:0] t6_nxt, t6_r3, t3_nxt, t3_r3;
  logic signed [63:0] v2_nxt, v2_r4, v1b_nxt, v1b_r4;
  logic [20:0]        pm;
  logic signed [63:0] xs_nxt, xs_r5, n1_nxt, n1_r5;
  logic signed [63:0] x_nxt, x_r6, num_nxt, num_r6;

  assign p1  = $signed({1'b0, coef.press_lo[15:0]});
  assign p2  = $signed(coef.press_lo[31:16]);
  assign p3  = $signed(coef.press_lo[47:32]);
  assign p5  = $signed(coef.press_hi[15:0]);
  assign p6  = $signed(coef.press_hi[31:16]);
  assign p4w = $signed({{13{coef.press_lo[63]}}, coef.press_lo[63:48], 35'b0});

  always_comb begin
    v1_nxt   = 34'(in_data.tf) - 34'sd128000;
    v1sq_nxt = v1_r1 * v1_r1;
    m5_nxt   = v1_r1 * p5;
    m2_nxt   = v1_r1 * p2;
    t6_nxt   = v1sq_r2 * p6;
    t3_nxt   = v1sq_r2 * p3;
    v2_nxt   = t6_r3 + (m5_r3 <<< 17) + p4w;
    v1b_nxt  = (t3_r3 >>> 8) + (m2_r3 <<< 12);
    pm       = 21'h100000 - {1'b0, side_r[3].adc_p};
    xs_nxt   = v1b_r4 + 64'sh0000_8000_0000_0000;
    n1_nxt   = $signed({12'b0, pm, 31'b0}) - v2_r4;
    x_nxt    = xs_r5 * p1;
    num_nxt  = n1_r5 * 64'sd3125;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[4:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    v1_r1   <= v1_nxt;
    v1sq_r2 <= v1sq_nxt;
    m5_r2   <= m5_nxt;
    m2_r2   <= m2_nxt;
    t6_r3   <= t6_nxt;
    t3_r3   <= t3_nxt;
    m5_r3   <= m5_r2;
    m2_r3   <= m2_r2;
    v2_r4   <= v2_nxt;
    v1b_r4  <= v1b_nxt;
    xs_r5   <= xs_nxt;
    n1_r5   <= n1_nxt;
    x_r6    <= x_nxt;
    num_r6  <= num_nxt;
    side_r[0] <= in_data;
    for (int i = 1; i < 6; i++) begin
      side_r[i] <= side_r[i-1];
    end
  end

  assign out_vld             = vld_r[5];
  assign out_data.temp_centi = side_r[5].temp_centi;
  assign out_data.hum        = side_r[5].hum;
  assign out_data.num        = num_r6;
  assign out_data.den        = $signed(x_r6[63:33]);

endmodule

// File: hw/rtl/src_div.sv
// pipelined signed divider, one quotient bit per stage, on magnitudes
// depends on src_pkg
module src_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_vld,
  input  src_pkg::pre_res_t     in_data,
  output logic                  out_vld,
  output src_pkg::div_res_t     out_data
);

  localparam int Stages = src_pkg::DIV_STAGES;
  localparam int NW     = src_pkg::NUM_W;
  localparam int DW     = src_pkg::DEN_W;

  logic [Stages:0]   vld_r;
  logic [DW-1:0]     rem_r  [Stages+1];
  logic [NW-1:0]     nq_r   [Stages+1];
  logic [DW-1:0]     md_r   [Stages+1];
  src_pkg::div_side_t side_r [Stages+1];

  logic [DW:0]   trial    [Stages];
  logic [DW:0]   diff     [Stages];
  logic [DW-1:0] rem_nxt  [Stages];
  logic [NW-1:0] nq_nxt   [Stages];

  logic [NW-1:0]     mn;
  logic [DW-1:0]     md;
  src_pkg::div_side_t side_nxt;

  always_comb begin
    mn = in_data.num[NW-1] ? (NW'(0) - in_data.num) : in_data.num;
    md = in_data.den[DW-1] ? (DW'(0) - in_data.den) : in_data.den;
    side_nxt.temp_centi = in_data.temp_centi;
    side_nxt.hum        = in_data.hum;
    side_nxt.invalid    = (in_data.den == '0);
    side_nxt.qneg       = in_data.num[NW-1] ^ in_data.den[DW-1];
  end

  // restoring step per stage
  always_comb begin
    for (int i = 0; i < Stages; i++) begin
      trial[i] = {rem_r[i], nq_r[i][NW-1]};
      diff[i]  = trial[i] - {1'b0, md_r[i]};
      if (trial[i] >= {1'b0, md_r[i]}) begin
        rem_nxt[i] = diff[i][DW-1:0];
        nq_nxt[i]  = {nq_r[i][NW-2:0], 1'b1};
      end else begin
        rem_nxt[i] = trial[i][DW-1:0];
        nq_nxt[i]  = {nq_r[i][NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[Stages-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0]  <= '0;
    nq_r[0]   <= mn;
    md_r[0]   <= md;
    side_r[0] <= side_nxt;
    for (int i = 0; i < Stages; i++) begin
      rem_r[i+1]  <= rem_nxt[i];
      nq_r[i+1]   <= nq_nxt[i];
      md_r[i+1]   <= md_r[i];
      side_r[i+1] <= side_r[i];
    end
  end

  assign out_vld             = vld_r[Stages];
  assign out_data.temp_centi = side_r[Stages].temp_centi;
  assign out_data.hum        = side_r[Stages].hum;
  assign out_data.invalid    = side_r[Stages].invalid;
  assign out_data.qneg       = side_r[Stages].qneg;
  assign out_data.quo        = nq_r[Stages];

endmodule

// File: hw/rtl/src_ppost.sv
// pressure stages after the divider: second-order correction and final q24.8 value
// depends on src_pkg
module src_ppost (
  input  logic                  clk,
  input  logic                  rst_n,
  input  src_pkg::coef_t        coef,
  input  logic                  in_vld,
  input  src_pkg::div_res_t     in_data,
  output logic                  out_vld,
  output src_pkg::out_t         out_data
);

  logic [5:0] vld_r;
  src_pkg::div_res_t side_r [5];

  logic signed [15:0] p8, p9;
  logic [31:0]        p7x;

  logic signed [63:0] p_nxt, p_r1, p_r2, p_r3, p_r4;
  logic signed [63:0] ps, a1_nxt, a1_r2, ps_r2, m8_nxt, m8_r2;
  logic [63:0]        ll_nxt, ll_r3;
  logic [31:0]        lh_nxt, lh_r3, hl_nxt, hl_r3;
  logic signed [63:0] v2_r3, v2_r4, a2_nxt, a2_r4;
  logic signed [63:0] sum_nxt, sum_r5, sh;
  logic [31:0]        pr;
  src_pkg::out_t      out_nxt, out_r;

  assign p8  = $signed(coef.press_hi[63:48]);
  assign p9  = $signed(coef.press_p9);
  assign p7x = {{12{coef.press_hi[47]}}, coef.press_hi[47:32], 4'b0};

  always_comb begin
    p_nxt   = in_data.qneg ? (64'sd0 - $signed(in_data.quo)) : $signed(in_data.quo);
    ps      = p_r1 >>> 13;
    a1_nxt  = ps * p9;
    m8_nxt  = p_r1 * p8;
    ll_nxt  = {32'b0, a1_r2[31:0]} * {32'b0, ps_r2[31:0]};
    lh_nxt  = a1_r2[31:0] * ps_r2[63:32];
    hl_nxt  = a1_r2[63:32] * ps_r2[31:0];
    a2_nxt  = $signed(ll_r3 + {lh_r3 + hl_r3, 32'b0});
    sum_nxt = p_r4 + (a2_r4 >>> 25) + v2_r4;
    sh      = sum_r5 >>> 8;
    pr      = sh[31:0] + p7x;
    out_nxt.temperature_centi = side_r[4].temp_centi;
    out_nxt.humidity_q22_10   = side_r[4].hum;
    out_nxt.pressure_invalid  = side_r[4].invalid;
    out_nxt.pressure_q24_8    = side_r[4].invalid ? 32'd0 : pr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[4:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    p_r1   <= p_nxt;
    a1_r2  <= a1_nxt;
    ps_r2  <= ps;
    m8_r2  <= m8_nxt;
    p_r2   <= p_r1;
    ll_r3  <= ll_nxt;
    lh_r3  <= lh_nxt;
    hl_r3  <= hl_nxt;
    v2_r3  <= m8_r2 >>> 19;
    p_r3   <= p_r2;
    a2_r4  <= a2_nxt;
    v2_r4  <= v2_r3;
    p_r4   <= p_r3;
    sum_r5 <= sum_nxt;
    out_r  <= out_nxt;
    side_r[0] <= in_data;
    for (int i = 1; i < 5; i++) begin
      side_r[i] <= side_r[i-1];
    end
  end

  assign out_vld  = vld_r[5];
  assign out_data = out_r;

endmodule

// File: hw/rtl/sensor_raw_compensation.sv
// top level of the barometric / humidity integer compensation pipeline
// depends on src_pkg, src_temp, src_hum, src_ppre, src_div, src_ppost
//
// usage:
//   a measurement burst (in_data) is taken at every rising edge with start high;
//   busy stays low, so a new burst may follow in every cycle
//   out_valid is high for one cycle with out_data holding temperature, pressure,
//   the zero-divisor flag and humidity; the receiver cannot stall this channel
//   results come out in order, one result per
//   transaction; throughput is one burst per cycle
//   the pipeline holds the divider, an input register plus 64 stages of one
//   quotient bit each, and 25 stages of multiply and add for the other steps
//   coefficient registers are written on the cfg channel (cfg_ready always high);
//   write them only while no transaction is in flight
//   rst_n (synchronous, active low) clears the coefficients to zero and drops
//   every in-flight transaction
module sensor_raw_compensation (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  src_pkg::in_t                    in_data,
  output logic                            out_valid,
  output src_pkg::out_t                   out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [src_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [63:0]                     cfg_data
);

  src_pkg::coef_t coef_r;

  logic                  temp_vld, hum_vld, pre_vld, div_vld;
  src_pkg::temp_res_t    temp_res;
  src_pkg::hum_res_t     hum_res;
  src_pkg::pre_res_t     pre_res;
  src_pkg::div_res_t     div_res;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        src_pkg::REG_TEMP:     coef_r.temp     <= cfg_data[47:0];
        src_pkg::REG_PRESS_LO: coef_r.press_lo <= cfg_data;
        src_pkg::REG_PRESS_HI: coef_r.press_hi <= cfg_data;
        src_pkg::REG_PRESS_P9: coef_r.press_p9 <= cfg_data[15:0];
        src_pkg::REG_HUM:      coef_r.hum      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  src_temp u_temp (
    .clk      (clk),
    .rst_n    (rst_n),
    .coef     (coef_r),
    .in_vld   (start && !busy),
    .in_data  (in_data),
    .out_vld  (temp_vld),
    .out_data (temp_res)
  );

  src_hum u_hum (
    .clk      (clk),
    .rst_n    (rst_n),
    .coef     (coef_r),
    .in_vld   (temp_vld),
    .in_data  (temp_res),
    .out_vld  (hum_vld),
    .out_data (hum_res)
  );

  src_ppre u_ppre (
    .clk      (clk),
    .rst_n    (rst_n),
    .coef     (coef_r),
    .in_vld   (hum_vld),
    .in_data  (hum_res),
    .out_vld  (pre_vld),
    .out_data (pre_res)
  );

  src_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (pre_vld),
    .in_data  (pre_res),
    .out_vld  (div_vld),
    .out_data (div_res)
  );

  src_ppost u_ppost (
    .clk      (clk),
    .rst_n    (rst_n),
    .coef     (coef_r),
    .in_vld   (div_vld),
    .in_data  (div_res),
    .out_vld  (out_valid),
    .out_data (out_data)
  );

endmodule

// File: sim/tb_top.sv
// self-checking testbench for sensor_raw_compensation: random and directed bursts,
// coefficient sets changed between phases, results checked against an internal predictor
// depends on src_pkg and the rtl of the block
`timescale 1ns / 1ps

module tb_top;

  localparam int LATENCY   = 90;
  localparam int MAX_CYCLE = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  src_pkg::in_t in_data = '0;
  logic out_valid;
  src_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [src_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  sensor_raw_compensation u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  src_pkg::coef_t coef = '0;
  src_pkg::in_t burst_q[$];
  src_pkg::out_t expected_q[$];
  int mismatches = 0;
  int cycles = 0;
  int idle_left = 0;
  bit quiet = 1'b0;

  function automatic logic [31:0] sx(logic [63:0] v, int w);
    logic [31:0] r;
    r = v[31:0] & ((32'd1 << w) - 1);
    if (v[w-1]) r = r | ~((32'd1 << w) - 1);
    return r;
  endfunction

  function automatic logic signed [63:0] sx64(logic [63:0] v, int w);
    return $signed(sx(v, w));
  endfunction

  function automatic src_pkg::out_t compensate(src_pkg::in_t b);
    src_pkg::out_t r;
    logic [31:0] adc_p, adc_t, adc_h, t1, t2, t3, a, d, bb, tf, tc;
    logic [31:0] h1, h2, h3, h4, h5, h6, v, ha, hc, s;
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, w1, w2, p, num;
    logic [63:0] mn, md, q;
    adc_p = {b.press_msb, b.press_lsb, b.press_xlsb[7:4]};
    adc_t = {b.temp_msb, b.temp_lsb, b.temp_xlsb[7:4]};
    adc_h = {b.hum_msb, b.hum_lsb};
    t1 = coef.temp[15:0];
    t2 = sx(coef.temp[31:16], 16);
    t3 = sx(coef.temp[47:32], 16);
    a = $signed((adc_t >> 3) - (t1 << 1)) * $signed(t2);
    a = $signed(a) >>> 11;
    d = (adc_t >> 4) - t1;
    bb = $signed(d * d) >>> 12;
    bb = $signed(bb * t3) >>> 14;
    tf = a + bb;
    tc = $signed(tf * 5 + 128) >>> 8;
    r.temperature_centi = tc;
    p1 = coef.press_lo[15:0];
    p2 = sx64(coef.press_lo[31:16], 16);
    p3 = sx64(coef.press_lo[47:32], 16);
    p4 = sx64(coef.press_lo[63:48], 16);
    p5 = sx64(coef.press_hi[15:0], 16);
    p6 = sx64(coef.press_hi[31:16], 16);
    p7 = sx64(coef.press_hi[47:32], 16);
    p8 = sx64(coef.press_hi[63:48], 16);
    p9 = sx64(coef.press_p9, 16);
    w1 = $signed(tf) - 64'sd128000;
    w2 = w1 * w1 * p6;
    w2 = w2 + ((w1 * p5) <<< 17);
    w2 = w2 + (p4 <<< 35);
    w1 = ((w1 * w1 * p3) >>> 8) + ((w1 * p2) <<< 12);
    w1 = (((64'sd1 <<< 47) + w1) * p1) >>> 33;
    r.pressure_invalid = (w1 == 0);
    r.pressure_q24_8 = '0;
    if (w1 != 0) begin
      p = 64'sd1048576 - $signed({32'd0, adc_p});
      num = ((p <<< 31) - w2) * 64'sd3125;
      mn = num[63] ? -num : num;
      md = w1[63] ? -w1 : w1;
      q = mn / md;
      p = (num[63] != w1[63]) ? -q : q;
      w1 = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
      w2 = (p8 * p) >>> 19;
      p = ((p + w1 + w2) >>> 8) + (p7 <<< 4);
      r.pressure_q24_8 = p[31:0];
    end
    h1 = coef.hum[7:0];
    h2 = sx(coef.hum[23:8], 16);
    h3 = coef.hum[31:24];
    h4 = sx(coef.hum[43:32], 12);
    h5 = sx(coef.hum[55:44], 12);
    h6 = sx(coef.hum[63:56], 8);
    v = tf - 32'd76800;
    ha = $signed((adc_h << 14) - ((h4 << 20) + h5 * v) + 32'd16384) >>> 15;
    hc = ($signed(v * h6) >>> 10);
    hc = hc * ($unsigned($signed(v * h3) >>> 11) + 32'd32768);
    hc = $unsigned($signed(hc) >>> 10) + 32'd2097152;
    hc = $signed(hc * h2 + 32'd8192) >>> 14;
    v = ha * hc;
    s = $signed(v) >>> 15;
    s = $signed(s * s) >>> 7;
    v = v - $unsigned($signed(s * h1) >>> 4);
    if (v[31]) v = 0;
    else if (v > 32'd419430400) v = 32'd419430400;
    r.humidity_q22_10 = v[28:12];
    return r;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        expected_q.push_back(compensate(in_data));
        void'(burst_q.pop_front());
      end
      if (idle_left > 0) begin
        idle_left <= idle_left - 1;
        start <= 1'b0;
      end else if (burst_q.size() > 0) begin
        if (!quiet && $urandom_range(0, 7) == 0) begin
          idle_left <= $urandom_range(1, 8);
          start <= 1'b0;
        end else begin
          in_data <= burst_q[0];
          start <= 1'b1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    src_pkg::out_t e;
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected transaction %p", out_data);
      end else begin
        e = expected_q.pop_front();
        if (e !== out_data) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("mismatch exp %p got %p", e, out_data);
        end
      end
    end
    if (cycles > MAX_CYCLE) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(logic [src_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      src_pkg::REG_TEMP:     coef.temp = val[47:0];
      src_pkg::REG_PRESS_LO: coef.press_lo = val;
      src_pkg::REG_PRESS_HI: coef.press_hi = val;
      src_pkg::REG_PRESS_P9: coef.press_p9 = val[15:0];
      src_pkg::REG_HUM:      coef.hum = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (burst_q.size() > 0 || start || expected_q.size() > 0) @(posedge clk);
    repeat (LATENCY / 4) @(posedge clk);
  endtask

  function automatic src_pkg::in_t rand_burst();
    src_pkg::in_t b;
    b = {$urandom, $urandom};
    // realistic counts most of the time
    if ($urandom_range(0, 3) != 0) begin
      b.temp_msb = $urandom_range(100, 150);
      b.press_msb = $urandom_range(60, 110);
    end
    return b;
  endfunction

  function automatic logic [63:0] typical_set(int k);
    case (k)
      0: return {16'(-32'sd1000 + $urandom_range(0, 2000)), 16'd26000 + 16'($urandom_range(0, 2000)),
                 16'd27000 + 16'($urandom_range(0, 2000))};
      1: return {16'(3000 + $urandom_range(0, 2000)), 16'(-32'sd8000 + $urandom_range(0, 200)),
                 16'(-32'sd10600 + $urandom_range(0, 200)), 16'd36000 + 16'($urandom_range(0, 3000))};
      2: return {16'(4000 + $urandom_range(0, 1000)), 16'(15000 + $urandom_range(0, 1000)),
                 16'(-32'sd7 - $urandom_range(0, 5)), 16'($urandom_range(0, 200))};
      3: return 64'(16'(6000 + $urandom_range(0, 1000)));
      default: return {8'd30, 12'(50), 12'(300 + $urandom_range(0, 100)),
                       8'd0, 16'(360 + $urandom_range(0, 20)), 8'd75};
    endcase
  endfunction

  initial begin
    src_pkg::in_t b;
    logic [63:0] v;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // directed: reset coefficients, zero divisor
    burst_q.push_back('0);
    burst_q.push_back('1);
    burst_q.push_back(64'h80_00_0F_80_00_0F_80_00);
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      for (int k = 0; k < 5; k++) begin
        if (ph == 1) v = '1;
        else if (ph == 2) v = {1'b0, 63'h0} | 64'h8000_8000_8000_8000;
        else if (ph == 3 || ph % 2 == 0) v = typical_set(k);
        else v = {$urandom, $urandom};
        write_reg(k[src_pkg::CFG_IDX_W-1:0], v);
      end
      if (ph == 0) begin
        burst_q.push_back('0);
        burst_q.push_back('1);
        for (int i = 0; i < 8; i++) begin
          b = '0;
          b[i*8 +: 8] = 8'hFF;
          burst_q.push_back(b);
        end
        burst_q.push_back(64'h55_5F_50_85_5F_50_AA_55);
        burst_q.push_back(64'hAA_A0_A0_7A_A0_A0_55_AA);
        burst_q.push_back(64'h80_00_0F_80_00_0F_80_00);
      end
      quiet = (ph == 7);
      for (int i = 0; i < 200; i++) burst_q.push_back(rand_burst());
      drain();
    end
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
